/* design/pme_pkg.sv */
// ----------------------------------------------------------------------------
// pme_pkg
// Shared constants, types and helper functions of the polynomial map evaluator.
// ----------------------------------------------------------------------------
package pme_pkg;

  localparam int MAX_ORDER     = 5;
  localparam int MAX_DIMENSION = 3;
  localparam int FAST_ORDER    = 2;
  localparam int DATA_W        = 32;
  localparam int FRAC_W        = 24;
  localparam int INDEX_W       = 8;

  localparam int MAX_COUNT   = (MAX_ORDER + 1) * (MAX_ORDER + 2) * (MAX_ORDER + 3) / 6;
  localparam int TABLE_DEPTH = MAX_DIMENSION * MAX_COUNT;
  localparam int MEM_AW      = $clog2(TABLE_DEPTH);
  localparam int EXP_W       = $clog2(MAX_ORDER + 1);
  localparam int CNT_W       = $clog2(MAX_COUNT + 1);
  localparam int SUM_W       = DATA_W + $clog2(MAX_COUNT) + 1;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) <<< FRAC_W;

  // Register indexes of the configuration port.
  localparam logic REG_DIMENSION  = 1'b0;
  localparam logic REG_POLY_ORDER = 1'b1;

  typedef struct packed {
    logic             is3d;
    logic [EXP_W-1:0] order;
  } pme_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_MUL,
    ST_POW_WB,
    ST_CROSS_MUL,
    ST_CROSS_WB,
    ST_RD,
    ST_MA,
    ST_MB,
    ST_MC,
    ST_ACC,
    ST_DONE
  } pme_state_t;

  // Number of monomials of total order up to n, without a divider.
  function automatic logic [CNT_W-1:0] term_count(input logic is3d, input logic [EXP_W-1:0] n);
    logic [CNT_W-1:0] tri_v;
    logic [CNT_W-1:0] tet_v;
    tri_v = '0;
    tet_v = '0;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      if (EXP_W'(i) <= n) begin
        tri_v = tri_v + CNT_W'(i + 1);
        tet_v = tet_v + tri_v;
      end
    end
    return is3d ? tet_v : tri_v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < SUM_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

/* design/pme_if.sv */
// ----------------------------------------------------------------------------
// pme_in_if / pme_out_if
// Valid/ready channels for input beats and mapped point beats.
// ----------------------------------------------------------------------------
interface pme_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [pme_pkg::INDEX_W-1:0]       coef_index;
  logic signed [pme_pkg::DATA_W-1:0] coef_value;
  logic signed [pme_pkg::DATA_W-1:0] point_x;
  logic signed [pme_pkg::DATA_W-1:0] point_y;
  logic signed [pme_pkg::DATA_W-1:0] point_z;

  modport source (output valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface pme_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pme_pkg::DATA_W-1:0] out_x;
  logic signed [pme_pkg::DATA_W-1:0] out_y;
  logic signed [pme_pkg::DATA_W-1:0] out_z;
  logic                              overflow;

  modport source (output valid, out_x, out_y, out_z, overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

/* design/pme_cfg.sv */
// ----------------------------------------------------------------------------
// pme_cfg
// APB-style register file holding dimension and polynomial order.
// ----------------------------------------------------------------------------
module pme_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pme_pkg::pme_cfg_t cfg
);

  logic [1:0] dim_r;
  logic [2:0] order_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= 2'd2;
      order_r <= 3'd2;
    end else if (wr_en) begin
      unique case (paddr[2])
        pme_pkg::REG_DIMENSION:  dim_r   <= pwdata[1:0];
        pme_pkg::REG_POLY_ORDER: order_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pme_pkg::REG_DIMENSION:  prdata = {30'd0, dim_r};
      pme_pkg::REG_POLY_ORDER: prdata = {29'd0, order_r};
      default:                 prdata = '0;
    endcase
  end

  // Orders beyond the supported maximum are clamped.
  assign cfg.is3d  = (dim_r == 2'd3) && (pme_pkg::MAX_DIMENSION >= 3);
  assign cfg.order = (32'(order_r) > 32'(pme_pkg::MAX_ORDER)) ?
                     pme_pkg::EXP_W'(pme_pkg::MAX_ORDER) : pme_pkg::EXP_W'(order_r);

endmodule

/* design/pme_coef_mem.sv */
// ----------------------------------------------------------------------------
// pme_coef_mem
// Coefficient table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pme_coef_mem (
  input  logic                              clk,
  input  logic                              we,
  input  logic [pme_pkg::MEM_AW-1:0]        waddr,
  input  logic signed [pme_pkg::DATA_W-1:0] wdata,
  input  logic                              re,
  input  logic [pme_pkg::MEM_AW-1:0]        raddr,
  output logic signed [pme_pkg::DATA_W-1:0] rdata
);

  logic signed [pme_pkg::DATA_W-1:0] mem [pme_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/pme_qmul.sv */
// ----------------------------------------------------------------------------
// pme_qmul
// Q8.24 multiplier: registered product, then round half up and saturate.
// ----------------------------------------------------------------------------
module pme_qmul (
  input  logic                              clk,
  input  logic signed [pme_pkg::DATA_W-1:0] a,
  input  logic signed [pme_pkg::DATA_W-1:0] b,
  output logic signed [pme_pkg::DATA_W-1:0] res,
  output logic                              sat
);

  localparam int PW = 2 * pme_pkg::DATA_W;
  localparam int SW = PW - pme_pkg::FRAC_W;

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] rnd;
  logic signed [SW-1:0] shf;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  // The product of two 32-bit values stays well below the 64-bit limit,
  // so adding the rounding half cannot wrap.
  assign rnd = prod_r + (PW'(1) <<< (pme_pkg::FRAC_W - 1));
  assign shf = SW'(rnd >>> pme_pkg::FRAC_W);

  always_comb begin
    sat = 1'b0;
    res = shf[pme_pkg::DATA_W-1:0];
    if (shf > SW'(signed'({1'b0, {(pme_pkg::DATA_W-1){1'b1}}}))) begin
      sat = 1'b1;
      res = {1'b0, {(pme_pkg::DATA_W-1){1'b1}}};
    end else if (shf < SW'(signed'({1'b1, {(pme_pkg::DATA_W-1){1'b0}}}))) begin
      sat = 1'b1;
      res = {1'b1, {(pme_pkg::DATA_W-1){1'b0}}};
    end
  end

endmodule

/* design/polynomial_map_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// polynomial_map_evaluator_unit
// One step of a 2-D or 3-D polynomial map from a coefficient table.
// ----------------------------------------------------------------------------
//   channel | direction | handshake     | beat
//   in_ch   | in        | valid/ready   | load coefficient or evaluate point
//   out_ch  | out       | valid/ready   | mapped point and overflow flag
//   cfg_*   | in        | APB, no waits | dimension, poly_order
//
// A load beat writes the table on acceptance and leaves the input open. A
// point beat runs a power step (multiply, write back) for each of the
// dim * order powers, a cross product step for each cross product at order
// two, then for each of the dim * count table terms a table read, three
// multiplies and an accumulate, and last hands the result to the output
// register. The single Q8.24 multiplier is shared by all of these steps.
// Reset is synchronous and clears control only; there is no table clear.
// A new beat is taken while a finished result still waits on out_ch.
// ----------------------------------------------------------------------------
module polynomial_map_evaluator_unit (
  input  logic        clk,
  input  logic        rst_n,
  pme_in_if.sink      in_ch,
  pme_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DW = pme_pkg::DATA_W;
  localparam int EW = pme_pkg::EXP_W;

  typedef logic signed [DW-1:0] q_t;

  pme_pkg::pme_cfg_t  cfg;
  pme_pkg::pme_state_t state_r, state_nxt;

  q_t x_r, y_r, z_r;
  q_t px_r [pme_pkg::MAX_ORDER+1];
  q_t py_r [pme_pkg::MAX_ORDER+1];
  q_t pz_r [pme_pkg::MAX_ORDER+1];
  q_t xy_r, xz_r, yz_r, last_r;
  q_t res_r [3];
  logic [1:0]                   pc_r, cc_r, comp_r;
  logic [EW-1:0]                pe_r, ex_r, ey_r, ez_r, n_r;
  logic [pme_pkg::CNT_W-1:0]    t_r, cnt_r;
  logic [pme_pkg::MEM_AW-1:0]   addr_r;
  logic signed [pme_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                         ov_r, is3d_r;

  q_t   mul_a, mul_b, qres, coef_rd, mono, coord;
  logic qsat, in_acc, mem_we, fast, last_term, last_pow, last_coord, last_cross;
  logic [EW+1:0] exp_sum;

  assign in_ch.ready = (state_r == pme_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign mem_we      = in_acc && !in_ch.mode &&
                       (32'(in_ch.coef_index) < 32'(pme_pkg::TABLE_DEPTH));

  pme_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  pme_coef_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(pme_pkg::MEM_AW'(in_ch.coef_index)),
    .wdata(in_ch.coef_value), .re(state_r == pme_pkg::ST_RD), .raddr(addr_r),
    .rdata(coef_rd)
  );

  pme_qmul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .res(qres), .sat(qsat));

  assign fast       = (32'(n_r) == 32'(pme_pkg::FAST_ORDER));
  assign last_term  = (t_r == cnt_r - 1'b1);
  assign last_pow   = (pe_r == n_r);
  assign last_coord = (pc_r == (is3d_r ? 2'd2 : 2'd1));
  assign last_cross = (cc_r == (is3d_r ? 2'd2 : 2'd0));
  assign exp_sum    = (EW+2)'(ex_r) + (EW+2)'(ey_r) + (EW+2)'(ez_r);
  assign sum_nxt    = sum_r + pme_pkg::SUM_W'(qres);

  // Order-two monomials in the fast term order.
  always_comb begin
    mono = pme_pkg::Q_ONE;
    if (is3d_r) begin
      case (t_r)
        4'd1:    mono = x_r;
        4'd2:    mono = y_r;
        4'd3:    mono = z_r;
        4'd4:    mono = px_r[2];
        4'd5:    mono = py_r[2];
        4'd6:    mono = pz_r[2];
        4'd7:    mono = xy_r;
        4'd8:    mono = xz_r;
        4'd9:    mono = yz_r;
        default: mono = pme_pkg::Q_ONE;
      endcase
    end else begin
      case (t_r)
        4'd1:    mono = x_r;
        4'd2:    mono = y_r;
        4'd3:    mono = px_r[2];
        4'd4:    mono = py_r[2];
        4'd5:    mono = xy_r;
        default: mono = pme_pkg::Q_ONE;
      endcase
    end
  end

  always_comb begin
    case (pc_r)
      2'd0:    coord = x_r;
      2'd1:    coord = y_r;
      default: coord = z_r;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      pme_pkg::ST_POW_MUL: begin
        mul_a = last_r;
        mul_b = coord;
      end
      pme_pkg::ST_CROSS_MUL: begin
        mul_a = (cc_r == 2'd2) ? y_r : x_r;
        mul_b = (cc_r == 2'd0) ? y_r : z_r;
      end
      pme_pkg::ST_MA: begin
        mul_a = coef_rd;
        mul_b = fast ? mono : px_r[ex_r];
      end
      pme_pkg::ST_MB: begin
        mul_a = qres;
        mul_b = fast ? pme_pkg::Q_ONE : py_r[ey_r];
      end
      pme_pkg::ST_MC: begin
        mul_a = qres;
        mul_b = fast ? pme_pkg::Q_ONE : pz_r[ez_r];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pme_pkg::ST_IDLE: begin
        if (in_acc && in_ch.mode) begin
          state_nxt = (cfg.order == '0) ? pme_pkg::ST_RD : pme_pkg::ST_POW_MUL;
        end
      end
      pme_pkg::ST_POW_MUL:   state_nxt = pme_pkg::ST_POW_WB;
      pme_pkg::ST_POW_WB: begin
        if (last_pow && last_coord) begin
          state_nxt = fast ? pme_pkg::ST_CROSS_MUL : pme_pkg::ST_RD;
        end else begin
          state_nxt = pme_pkg::ST_POW_MUL;
        end
      end
      pme_pkg::ST_CROSS_MUL: state_nxt = pme_pkg::ST_CROSS_WB;
      pme_pkg::ST_CROSS_WB:  state_nxt = last_cross ? pme_pkg::ST_RD : pme_pkg::ST_CROSS_MUL;
      pme_pkg::ST_RD:        state_nxt = pme_pkg::ST_MA;
      pme_pkg::ST_MA:        state_nxt = pme_pkg::ST_MB;
      pme_pkg::ST_MB:        state_nxt = pme_pkg::ST_MC;
      pme_pkg::ST_MC:        state_nxt = pme_pkg::ST_ACC;
      pme_pkg::ST_ACC: begin
        if (last_term && (comp_r == (is3d_r ? 2'd2 : 2'd1))) begin
          state_nxt = pme_pkg::ST_DONE;
        end else begin
          state_nxt = pme_pkg::ST_RD;
        end
      end
      pme_pkg::ST_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_nxt = pme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pme_pkg::ST_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pme_pkg::ST_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pme_pkg::ST_IDLE: begin
        if (in_acc && in_ch.mode) begin
          x_r    <= in_ch.point_x;
          y_r    <= in_ch.point_y;
          z_r    <= cfg.is3d ? in_ch.point_z : '0;
          is3d_r <= cfg.is3d;
          n_r    <= cfg.order;
          cnt_r  <= pme_pkg::term_count(cfg.is3d, cfg.order);
          px_r[0] <= pme_pkg::Q_ONE;
          py_r[0] <= pme_pkg::Q_ONE;
          pz_r[0] <= pme_pkg::Q_ONE;
          last_r <= pme_pkg::Q_ONE;
          pc_r   <= '0;
          pe_r   <= EW'(1);
          cc_r   <= '0;
          ex_r   <= '0;
          ey_r   <= '0;
          ez_r   <= '0;
          t_r    <= '0;
          addr_r <= '0;
          comp_r <= '0;
          sum_r  <= '0;
          ov_r   <= 1'b0;
          for (int i = 0; i < 3; i++) res_r[i] <= '0;
        end
      end
      pme_pkg::ST_POW_WB: begin
        ov_r <= ov_r | qsat;
        case (pc_r)
          2'd0:    px_r[pe_r] <= qres;
          2'd1:    py_r[pe_r] <= qres;
          default: pz_r[pe_r] <= qres;
        endcase
        if (last_pow) begin
          last_r <= pme_pkg::Q_ONE;
          pe_r   <= EW'(1);
          pc_r   <= pc_r + 2'd1;
        end else begin
          last_r <= qres;
          pe_r   <= pe_r + 1'b1;
        end
      end
      pme_pkg::ST_CROSS_WB: begin
        ov_r <= ov_r | qsat;
        case (cc_r)
          2'd0:    xy_r <= qres;
          2'd1:    xz_r <= qres;
          default: yz_r <= qres;
        endcase
        cc_r <= cc_r + 2'd1;
      end
      pme_pkg::ST_MB, pme_pkg::ST_MC: ov_r <= ov_r | qsat;
      pme_pkg::ST_ACC: begin
        addr_r <= addr_r + 1'b1;
        if (last_term) begin
          res_r[comp_r] <= pme_pkg::sat_sum(sum_nxt);
          ov_r   <= ov_r | qsat | (pme_pkg::SUM_W'(pme_pkg::sat_sum(sum_nxt)) != sum_nxt);
          comp_r <= comp_r + 2'd1;
          sum_r  <= '0;
          t_r    <= '0;
          ex_r   <= '0;
          ey_r   <= '0;
          ez_r   <= '0;
        end else begin
          ov_r  <= ov_r | qsat;
          sum_r <= sum_nxt;
          t_r   <= t_r + 1'b1;
          // x exponent runs innermost, then y, then z.
          if (exp_sum == (EW+2)'(n_r)) begin
            ex_r <= '0;
            if ((EW+1)'(ey_r) + (EW+1)'(ez_r) == (EW+1)'(n_r)) begin
              ey_r <= '0;
              ez_r <= ez_r + 1'b1;
            end else begin
              ey_r <= ey_r + 1'b1;
            end
          end else begin
            ex_r <= ex_r + 1'b1;
          end
        end
      end
      pme_pkg::ST_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_ch.out_x    <= res_r[0];
          out_ch.out_y    <= res_r[1];
          out_ch.out_z    <= res_r[2];
          out_ch.overflow <= ov_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/pme_checker.sv */
// ----------------------------------------------------------------------------
// pme_checker
// Port-level checks of the polynomial map evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pme_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_pready
);

  // A point beat keeps the input closed while it is evaluated.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode) |=> !in_ready)
    else $error("input accepted right after a point beat");

  // A load beat never leaves the input closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_mode) |=> in_ready)
    else $error("input closed after a load beat");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk) cfg_pready)
    else $error("configuration port inserted a wait state");

endmodule

bind polynomial_map_evaluator_unit pme_checker u_pme_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_mode(in_ch.mode),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .cfg_pready(cfg_pready)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the polynomial map evaluator against its own Q8.24 predictor. The
// coefficient table is filled first, then points are mapped under every
// dimension and order setting, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  CYCLE_LIMIT  = 6000000;
  localparam int  SETTLE       = 700;
  localparam int  DIRECT_DEPTH = 168;
  localparam logic [2:0] ADDR_DIMENSION  = 3'd0;
  localparam logic [2:0] ADDR_POLY_ORDER = 3'd4;

  typedef struct {
    int ox;
    int oy;
    int oz;
    bit ovf;
  } mapped_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic       cfg_psel = 1'b0;
  logic       cfg_penable = 1'b0;
  logic       cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pme_in_if  in_ch ();
  pme_out_if out_ch ();

  polynomial_map_evaluator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  int      coef_tab [DIRECT_DEPTH];
  bit [1:0] dim_reg = 2'd2;
  bit [2:0] order_reg = 3'd2;
  bit      sat_seen;
  mapped_t mapped_queue [$];
  int      fail_count = 0;
  int      snd_idle = 0;
  int      rcv_idle = 0;
  longint  cycle_count = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = (a * b + 64'sd8388608) >>> pme_pkg::FRAC_W;
    return clip32(p);
  endfunction

  function automatic longint q_pow(longint v, int e);
    longint r;
    r = longint'(pme_pkg::Q_ONE);
    for (int i = 0; i < e; i++) r = q_mul(r, v);
    return r;
  endfunction

  function automatic mapped_t map_point(int px, int py, int pz);
    mapped_t res;
    int d, n, cnt, base, t;
    longint x, y, z, s, v, one, x2, y2, xy;
    longint acc [3];
    longint mono [10];
    d = (dim_reg == 2'd3) ? 3 : 2;
    n = (order_reg > pme_pkg::MAX_ORDER) ? pme_pkg::MAX_ORDER : order_reg;
    cnt = (d == 3) ? (n + 1) * (n + 2) * (n + 3) / 6 : (n + 1) * (n + 2) / 2;
    one = longint'(pme_pkg::Q_ONE);
    x = px;
    y = py;
    z = (d == 3) ? longint'(pz) : 0;
    sat_seen = 1'b0;
    acc = '{0, 0, 0};
    for (int c = 0; c < d; c++) begin
      base = c * cnt;
      t = 0;
      s = 0;
      if (n == pme_pkg::FAST_ORDER) begin
        x2 = q_mul(x, x);
        y2 = q_mul(y, y);
        xy = q_mul(x, y);
        if (d == 2) begin
          mono = '{one, x, y, x2, y2, xy, 0, 0, 0, 0};
        end else begin
          mono = '{one, x, y, z, x2, y2, 0, xy, 0, 0};
          mono[6] = q_mul(z, z);
          mono[8] = q_mul(x, z);
          mono[9] = q_mul(y, z);
        end
        for (int m = 0; m < ((d == 2) ? 6 : 10); m++)
          s += q_mul(longint'(coef_tab[base + m]), mono[m]);
      end else begin
        for (int i = 0; i <= n; i++) begin
          for (int j = 0; j <= n - i; j++) begin
            if (d == 2) begin
              v = q_mul(longint'(coef_tab[base + t]), q_pow(x, j));
              s += q_mul(v, q_pow(y, i));
              t++;
            end else begin
              for (int k = 0; k <= n - i - j; k++) begin
                v = q_mul(longint'(coef_tab[base + t]), q_pow(x, k));
                v = q_mul(v, q_pow(y, j));
                s += q_mul(v, q_pow(z, i));
                t++;
              end
            end
          end
        end
      end
      acc[c] = clip32(s);
    end
    res.ox = int'(acc[0]);
    res.oy = int'(acc[1]);
    res.oz = int'(acc[2]);
    res.ovf = sat_seen;
    return res;
  endfunction

  // Mostly moderate Q8.24 values so sums stay in range, with some extremes.
  function automatic int rand_q();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $signed($urandom_range(67108864)) - 33554432;
    if (sel < 80) return $urandom;
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return int'(pme_pkg::Q_ONE);
      3: return -int'(pme_pkg::Q_ONE);
      default: return 0;
    endcase
  endfunction

  // ---------------- channel drivers ----------------
  task automatic send_beat(bit mode, int idx, int cval, int px, int py, int pz);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.coef_index <= idx[7:0];
    in_ch.coef_value <= cval;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (mode) begin
      mapped_queue.push_back(map_point(px, py, pz));
    end else if (idx < DIRECT_DEPTH) begin
      coef_tab[idx] = cval;
    end
  endtask

  task automatic load_coef(int idx, int cval);
    send_beat(1'b0, idx, cval, $urandom, $urandom, $urandom);
  endtask

  task automatic map_beat(int px, int py, int pz);
    send_beat(1'b1, $urandom_range(255), $urandom, px, py, pz);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (mapped_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_DIMENSION) dim_reg = data[1:0];
    else order_reg = data[2:0];
  endtask

  task automatic set_map(int d, int n);
    write_reg(ADDR_DIMENSION, {$urandom} & 32'hffff_fffc | 32'(d));
    write_reg(ADDR_POLY_ORDER, {$urandom} & 32'hffff_fff8 | 32'(n));
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    mapped_t exp_pt;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mapped_queue.size() == 0) begin
        $error("mapped point beat with no point pending");
        fail_count++;
      end else begin
        exp_pt = mapped_queue.pop_front();
        if (out_ch.out_x !== exp_pt.ox) begin
          $error("out_x expected %0d actual %0d", exp_pt.ox, out_ch.out_x);
          fail_count++;
        end
        if (out_ch.out_y !== exp_pt.oy) begin
          $error("out_y expected %0d actual %0d", exp_pt.oy, out_ch.out_y);
          fail_count++;
        end
        if (out_ch.out_z !== exp_pt.oz) begin
          $error("out_z expected %0d actual %0d", exp_pt.oz, out_ch.out_z);
          fail_count++;
        end
        if (out_ch.overflow !== exp_pt.ovf) begin
          $error("overflow expected %0d actual %0d", exp_pt.ovf, out_ch.overflow);
          fail_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_table_fill();
    for (int i = 0; i < DIRECT_DEPTH; i++) load_coef(i, rand_q());
    // Slots past the table must be dropped silently.
    load_coef(DIRECT_DEPTH, 32'h7fffffff);
    load_coef(255, 32'h80000000);
    wait_drained();
  endtask

  task automatic test_extreme_points();
    map_beat(0, 0, 0);
    map_beat(int'(pme_pkg::Q_ONE), -int'(pme_pkg::Q_ONE), int'(pme_pkg::Q_ONE));
    map_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    map_beat(32'h80000000, 32'h7fffffff, 32'h80000000);
    map_beat(32'h7fffffff, 32'h7fffffff, 0);
    wait_drained();
    set_map(3, 2);
    map_beat(32'h80000000, 32'h80000000, 32'h80000000);
    map_beat(int'(pme_pkg::Q_ONE), int'(pme_pkg::Q_ONE), -int'(pme_pkg::Q_ONE));
    map_beat(0, 0, 32'h7fffffff);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    for (int d = 0; d < 4; d++) begin
      for (int n = 0; n < 8; n++) begin
        set_map(d, n);
        map_beat(rand_q(), rand_q(), rand_q());
        map_beat(rand_q(), rand_q(), rand_q());
        wait_drained();
      end
    end
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, int beats);
    int left;
    int d, n;
    snd_idle = snd_pct;
    rcv_idle = rcv_pct;
    left = beats;
    while (left > 0) begin
      // Keep the slow high-order settings in the minority.
      d = $urandom_range(3);
      n = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2);
      set_map(d, n);
      for (int i = 0; i < 40 && left > 0; i++, left--) begin
        if ($urandom_range(99) < 70) begin
          map_beat(rand_q(), rand_q(), rand_q());
        end else if ($urandom_range(9) == 0) begin
          load_coef($urandom_range(255, DIRECT_DEPTH), $urandom);
        end else begin
          load_coef($urandom_range(DIRECT_DEPTH - 1), rand_q());
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_extreme_points();
    test_config_sweep();
    test_random_traffic(23, 65, 500);
    test_random_traffic(65, 23, 500);
    test_random_traffic(0, 0, 510);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pme_pkg.sv
design/pme_if.sv
design/pme_cfg.sv
design/pme_coef_mem.sv
design/pme_qmul.sv
design/polynomial_map_evaluator_unit.sv
design/pme_checker.sv
verif/testbench.sv
